[rtl/core/lnfq_pkg.sv]
// Shared constants, payload types and state codes for the newline line framer queue.
package lnfq_pkg;

  localparam int LINE_MAX    = 32;
  localparam int QUEUE_SLOTS = 4;

  // one spare buffer beyond the queued slots holds the partial line
  localparam int BUFS        = QUEUE_SLOTS + 1;
  localparam int STORE_DEPTH = BUFS * LINE_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BUF_W       = $clog2(BUFS);
  localparam int IDX_W       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LEN_W       = $clog2(LINE_MAX + 1);
  localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_QUEUED      = 3'd1;
  localparam logic [2:0] ST_IGNORED     = 3'd2;
  localparam logic [2:0] ST_FAULT       = 3'd3;
  localparam logic [2:0] ST_CHAR        = 3'd4;
  localparam logic [2:0] ST_NOLINE      = 3'd5;
  localparam logic [2:0] ST_NOROOM      = 3'd6;
  localparam logic [2:0] ST_FAULT_EMPTY = 3'd7;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       chunk_end;
    logic [7:0] capacity;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] line_char;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } lnfq_push_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } lnfq_state_t;

  function automatic logic [BUF_W-1:0] buf_next(input logic [BUF_W-1:0] b);
    logic [BUF_W-1:0] r;
    if (b == BUF_W'(BUFS - 1)) begin
      r = '0;
    end else begin
      r = b + BUF_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [BUF_W-1:0] b,
                                                   input logic [IDX_W-1:0] i);
    return ADDR_W'(b) * ADDR_W'(LINE_MAX) + ADDR_W'(i);
  endfunction

endpackage

[rtl/core/newline_line_framer_queue.sv]
// A byte item's single result is registered in the output stage in the cycle
// after acceptance. One byte item a cycle while the output is free. A line read
// takes no new item until its last character is pushed; characters come from
// the line store's single registered read port, one a cycle while out_free.
// Reset (synchronous, rst_n low) empties the ring and clears dropping and fault.
module newline_line_framer_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lnfq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lnfq_pkg::out_item_t out_data
);
  import lnfq_pkg::*;

  lnfq_state_t      state_r, state_nxt;
  logic [BUF_W-1:0] head_r, head_nxt;
  logic [BUF_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             drop_r, drop_nxt;
  logic             fault_r, fault_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [LEN_W-1:0] len_mem [BUFS];
  logic             len_we;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  lnfq_push_t push;
  logic       out_free;
  logic       accept;
  logic [LEN_W-1:0] head_len;
  logic       char_last;

  assign head_len  = len_mem[head_r];
  assign char_last = (LEN_W'(idx_r) + LEN_W'(1)) == head_len;
  assign in_ready  = (state_r == FSM_IDLE) && out_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    plen_nxt  = plen_r;
    drop_nxt  = drop_r;
    fault_nxt = fault_r;
    idx_nxt   = idx_r;
    len_we    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = store_addr(tail_r, plen_r[IDX_W-1:0]);
    ram_re    = 1'b0;
    ram_raddr = store_addr(head_r, '0);
    push.load = 1'b0;
    push.item = '{status: ST_IGNORED, line_char: 8'h00, last: 1'b1};

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          push.load = 1'b1;
          if (in_data.opcode == OP_BYTE) begin
            if (fault_r || in_data.rx_byte == CH_CR) begin
              push.item.status = ST_IGNORED;
            end else if (in_data.rx_byte == CH_LF) begin
              if (drop_r) begin
                drop_nxt         = 1'b0;
                plen_nxt         = '0;
                fault_nxt        = 1'b1;
                push.item.status = ST_FAULT;
              end else if (plen_r == '0) begin
                push.item.status = ST_IGNORED;
              end else if (count_r == CNT_W'(QUEUE_SLOTS)) begin
                fault_nxt        = 1'b1;
                push.item.status = ST_FAULT;
              end else begin
                // the partial buffer becomes the queued slot; advance to a fresh one
                len_we           = 1'b1;
                tail_nxt         = buf_next(tail_r);
                plen_nxt         = '0;
                count_nxt        = count_r + CNT_W'(1);
                push.item.status = ST_QUEUED;
              end
            end else if (drop_r) begin
              push.item.status = ST_IGNORED;
            end else if (plen_r == LEN_W'(LINE_MAX)) begin
              plen_nxt         = '0;
              drop_nxt         = 1'b1;
              push.item.status = ST_IGNORED;
            end else begin
              ram_we           = 1'b1;
              plen_nxt         = plen_r + LEN_W'(1);
              push.item.status = ST_STORED;
            end
          end else begin
            if (count_r == '0) begin
              push.item.status = fault_r ? ST_FAULT_EMPTY : ST_NOLINE;
            end else if (9'(head_len) >= 9'(in_data.capacity)) begin
              fault_nxt        = 1'b1;
              push.item.status = ST_NOROOM;
            end else if (head_len == '0) begin
              head_nxt         = buf_next(head_r);
              count_nxt        = count_r - CNT_W'(1);
              push.item.status = ST_NOLINE;
            end else begin
              // first character is fetched now; results follow from the read state
              push.load = 1'b0;
              ram_re    = 1'b1;
              idx_nxt   = '0;
              state_nxt = FSM_READ;
            end
          end
        end
      end
      FSM_READ: begin
        if (out_free) begin
          push.load           = 1'b1;
          push.item.status    = ST_CHAR;
          push.item.line_char = ram_rdata;
          push.item.last      = char_last;
          if (char_last) begin
            head_nxt  = buf_next(head_r);
            count_nxt = count_r - CNT_W'(1);
            state_nxt = FSM_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = store_addr(head_r, idx_r + IDX_W'(1));
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      plen_r  <= '0;
      drop_r  <= 1'b0;
      fault_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      plen_r  <= plen_nxt;
      drop_r  <= drop_nxt;
      fault_r <= fault_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= plen_r;
    end
  end

  lnfq_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lnfq_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/lnfq_ram.sv]
// Generic simple dual-port RAM with registered read data.
module lnfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/lnfq_out_stage.sv]
// Output register stage for result items.
module lnfq_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  lnfq_pkg::lnfq_push_t push,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output lnfq_pkg::out_item_t out_data
);
  import lnfq_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      data_r <= push.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[tb/sv/lnfq_line_checker.sv]
`timescale 1ns / 100ps
// Line framing predictor and result checker for the newline line framer queue.
module lnfq_line_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lnfq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lnfq_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  results_awaited
);
  import lnfq_pkg::*;

  logic [7:0]       slot_mem [QUEUE_SLOTS][LINE_MAX];
  logic [7:0]       partial_buf [LINE_MAX];
  logic [LEN_W-1:0] slot_len [QUEUE_SLOTS];
  logic [LEN_W-1:0] partial_len;
  logic [CNT_W-1:0] queued;
  int               head;
  logic             dropping;
  logic             faulted;
  int               errors = 0;

  out_item_t awaited_results[$];

  task automatic frame_byte(input logic [7:0] b, output logic [2:0] st);
    int tail;
    if (faulted || b == CH_CR) begin
      st = ST_IGNORED;
    end else if (b == CH_LF) begin
      if (dropping) begin
        // end of an overlong line: discard it and latch the fault
        dropping    = 1'b0;
        partial_len = '0;
        faulted     = 1'b1;
        st          = ST_FAULT;
      end else if (partial_len == 0) begin
        st = ST_IGNORED;
      end else if (queued == QUEUE_SLOTS) begin
        // ring full: keep the partial line as it is
        faulted = 1'b1;
        st      = ST_FAULT;
      end else begin
        tail = (head + int'(queued)) % QUEUE_SLOTS;
        for (int i = 0; i < LINE_MAX; i++) begin
          slot_mem[tail][i] = partial_buf[i];
        end
        slot_len[tail] = partial_len;
        partial_len    = '0;
        queued         = queued + 1'b1;
        st             = ST_QUEUED;
      end
    end else if (dropping) begin
      st = ST_IGNORED;
    end else if (partial_len == LINE_MAX) begin
      partial_len = '0;
      dropping    = 1'b1;
      st          = ST_IGNORED;
    end else begin
      partial_buf[partial_len] = b;
      partial_len              = partial_len + 1'b1;
      st                       = ST_STORED;
    end
  endtask

  task automatic frame_item(input in_item_t it);
    logic [2:0] st;
    int         len;
    if (it.opcode == OP_BYTE) begin
      frame_byte(it.rx_byte, st);
      awaited_results.push_back('{st, 8'h00, 1'b1});
    end else if (queued == 0) begin
      awaited_results.push_back('{faulted ? ST_FAULT_EMPTY : ST_NOLINE, 8'h00, 1'b1});
    end else begin
      len = int'(slot_len[head]);
      if (len >= int'(it.capacity)) begin
        // line stays queued, fault latches
        faulted = 1'b1;
        awaited_results.push_back('{ST_NOROOM, 8'h00, 1'b1});
      end else begin
        for (int i = 0; i < len; i++) begin
          awaited_results.push_back('{ST_CHAR, slot_mem[head][i], i == len - 1});
        end
        head   = (head + 1) % QUEUE_SLOTS;
        queued = queued - 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      partial_len = '0;
      queued      = '0;
      head        = 0;
      dropping    = 1'b0;
      faulted     = 1'b0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        frame_item(in_data);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with nothing awaited: status %0d char %02h last %0b",
                     $realtime, out_data.status, out_data.line_char, out_data.last);
          end
        end else begin
          want = awaited_results.pop_front();
          if (want !== out_data) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: expected status %0d char %02h last %0b, got %0d %02h %0b",
                       $realtime, want.status, want.line_char, want.last,
                       out_data.status, out_data.line_char, out_data.last);
            end
          end
        end
      end
    end
    results_awaited <= awaited_results.size();
    mismatches      <= errors;
  end

endmodule

[tb/sv/tb_newline_line_framer_queue.sv]
`timescale 1ns / 100ps
// Top of the newline line framer queue testbench: clock, reset, stimulus and verdict.
module tb_newline_line_framer_queue;
  import lnfq_pkg::*;

  typedef enum int {
    FLT_OVERLONG,
    FLT_RING_FULL,
    FLT_SHORT_CAP,
    FLT_ZERO_CAP
  } fault_kind_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        mismatches;
  int        results_awaited;

  int sent_count    = 0;
  bit sender_burst  = 1'b0;
  bit receiver_hold = 1'b0;

  // lengths of lines held in the ring, oldest first
  int line_lengths[$];

  newline_line_framer_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lnfq_line_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .results_awaited (results_awaited)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] cap);
    in_item_t it;
    int       gap;
    bit       ready_seen;
    it.opcode    = op;
    it.rx_byte   = b;
    it.chunk_end = 1'($urandom_range(0, 1));
    it.capacity  = cap;
    if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // ready only moves at the rising edge, so its mid-cycle value is the one the edge sees
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] cap);
    send_item(OP_READ, 8'($urandom_range(0, 255)), cap);
  endtask

  function automatic logic [7:0] data_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return LINE_MAX;
    if (r < 3) return $urandom_range(9, LINE_MAX - 1);
    return $urandom_range(1, 8);
  endfunction

  // carriage returns sprinkled in do not count towards the length
  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_byte(CH_CR);
      send_byte(data_char());
    end
    send_byte(CH_LF);
    line_lengths.push_back(len);
  endtask

  task automatic read_line();
    int len;
    if (line_lengths.size() == 0) begin
      send_read(8'($urandom_range(0, 255)));
    end else begin
      len = line_lengths.pop_front();
      send_read(8'($urandom_range(len + 1, 255)));
    end
  endtask

  initial begin : receiver
    int gap;
    bit receiver_burst;
    bit valid_seen;
    receiver_burst = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) receiver_burst = !receiver_burst;
      gap = receiver_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0 || receiver_hold) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (receiver_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        valid_seen = out_valid;
        @(posedge clk);
      end while (!valid_seen);
    end
  end

  // hold the receiver off long enough for the block to back up its input
  initial begin : long_hold
    wait (sent_count >= 80);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (400) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin : stimulus
    int          r;
    fault_kind_t kind;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty read, extreme characters, CR, empty line, exact-fit reads
    send_read(8'd255);
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_read(8'd3);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(CH_LF);
    send_byte(8'hFE);
    send_byte(CH_LF);
    send_read(8'd4);
    send_read(8'd2);
    send_read(8'd0);
    send_read(8'd255);

    // well-formed traffic without faults
    while (sent_count < 320) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if (line_lengths.size() < QUEUE_SLOTS) begin
          send_line(pick_length());
        end else begin
          read_line();
        end
      end else if (r < 85) begin
        read_line();
      end else if (r < 93) begin
        send_byte(CH_LF);
      end else begin
        send_byte(CH_CR);
      end
    end

    // raise the sticky fault by one of its causes
    kind = fault_kind_t'($urandom_range(0, 3));
    case (kind)
      FLT_OVERLONG: begin
        repeat (LINE_MAX + $urandom_range(1, 6)) send_byte(data_char());
        send_byte(CH_LF);
      end
      FLT_RING_FULL: begin
        while (line_lengths.size() < QUEUE_SLOTS) send_line(pick_length());
        repeat ($urandom_range(1, 5)) send_byte(data_char());
        send_byte(CH_LF);
      end
      FLT_SHORT_CAP: begin
        if (line_lengths.size() == 0) send_line(pick_length());
        send_read(8'($urandom_range(0, line_lengths[0])));
      end
      default: begin
        if (line_lengths.size() == 0) send_line(pick_length());
        send_read(8'd0);
      end
    endcase

    // after the fault: any byte, reads of random size, then drain the ring
    repeat (100) begin
      if ($urandom_range(0, 3) == 0) begin
        send_read(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    repeat (QUEUE_SLOTS + 2) send_read(8'd255);

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && results_awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
